@@ sv/sdac_pkg.sv @@
`default_nettype none

package sdac_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int RIDX_W   = 9;
	localparam int CMD_W    = 3;
	localparam int TB_W     = 4;
	localparam int SKIP_W   = 10;
	localparam int AVGC_W   = 3;
	localparam int ACC_W    = 15;

	// stream packing
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 64;

	localparam int BUFFER_DEPTH_DEF = 512;
	localparam int Q_DEPTH          = 2;
	localparam int Q_CNT_W          = 2;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
	localparam logic [TB_W-1:0]     TB_RESET   = 4'd15;

	// reciprocals for divide by 3 and 5, scaled by 2^17, exact for 15-bit sums
	localparam int              RECIP_SHIFT = 17;
	localparam logic [15:0]     RECIP3      = 16'd43691;
	localparam logic [15:0]     RECIP5      = 16'd26215;

	// command codes on the input stream
	localparam logic [CMD_W-1:0] CMD_SAMPLE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

	typedef enum logic [2:0] {
		OP_SAMPLE,
		OP_PAUSE,
		OP_RESUME,
		OP_RESTART,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [SAMPLE_W-1:0] sample;
		logic [RIDX_W-1:0]   rindex;
	} item_t;

	// averaging count per timebase
	function automatic logic [AVGC_W-1:0] avg_count(input logic [TB_W-1:0] tb);
		logic [AVGC_W-1:0] n;
		case (tb)
			4'd12:   n = 3'd4;
			4'd13:   n = 3'd3;
			4'd14:   n = 3'd2;
			4'd15:   n = 3'd1;
			default: n = 3'd5;
		endcase
		return n;
	endfunction

	// conversions skipped between taken ones, per timebase
	function automatic logic [SKIP_W-1:0] skip_count(input logic [TB_W-1:0] tb);
		logic [SKIP_W-1:0] n;
		case (tb)
			4'd0:    n = 10'd1000;
			4'd1:    n = 10'd500;
			4'd2:    n = 10'd200;
			4'd3:    n = 10'd100;
			4'd4:    n = 10'd50;
			4'd5:    n = 10'd20;
			4'd6:    n = 10'd10;
			4'd7:    n = 10'd5;
			4'd8:    n = 10'd2;
			4'd9:    n = 10'd1;
			default: n = 10'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

@@ sv/scope_decimate_average_capture_core.sv @@
`default_nettype none

// Channel   Dir  Handshake           Payload
// s         in   s_tvalid/s_tready   s_tdata: adc_sample, read_index; s_tuser: cmd
// m         out  m_tvalid/m_tready   m_tdata: averaged sample word; m_tuser: stored
// cfg       in   cfg_we              cfg_wdata: timebase_index
//
// Each command takes two back-end sequencer steps (execute, then finish);
// the divide-by-count product is registered between the two steps.
// The front end takes one transfer per cycle, while room remains, into a 2-entry
// queue, so input bursts are absorbed while the back end works or output stalls.
// arst_n clears all control state; the capture buffer holds no reset value.
// A stalled output holds the sequencer in its finish step until the transfer.

module scope_decimate_average_capture_core #(
	parameter int BUFFER_DEPTH = sdac_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [sdac_pkg::TB_W-1:0]          cfg_wdata,   // timebase_index
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// adc_sample [11:0], read_index [20:12], zero pad [23:21]
	input  wire logic [sdac_pkg::S_TDATA_W-1:0]     s_tdata,
	// cmd [2:0]
	input  wire logic [sdac_pkg::CMD_W-1:0]         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// stored_value [11:0], stored_position [20:12], capture_done [21],
	// max_value [33:22], min_value [45:34], read_data [57:46], zero pad [63:58]
	output logic [sdac_pkg::M_TDATA_W-1:0]          m_tdata,
	// stored [0]
	output logic                                    m_tuser
);

	logic                           push;
	logic                           q_full;
	logic                           q_valid;
	logic                           q_pop;
	logic [sdac_pkg::Q_CNT_W-1:0]   q_count;
	sdac_pkg::item_t                push_item;
	sdac_pkg::item_t                head;

	sdac_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.item     (push_item)
	);

	sdac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_full    (q_full),
		.head      (head),
		.q_count   (q_count)
	);

	sdac_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.head      (head),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// back end never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// queue never overfills
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < sdac_pkg::Q_CNT_W'(sdac_pkg::Q_DEPTH)))
		else $error("queue pushed while full");

	// a stored average lies within the reported extremes
	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((m_tdata[45:34] <= m_tdata[11:0]) &&
		                          (m_tdata[11:0] <= m_tdata[33:22])))
		else $error("stored average outside max/min");

endmodule

`default_nettype wire

@@ sv/sdac_front.sv @@
`default_nettype none

module sdac_front (
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [sdac_pkg::S_TDATA_W-1:0]     s_tdata,
	input  wire logic [sdac_pkg::CMD_W-1:0]         s_tuser,
	input  wire logic                               q_full,
	output logic                                    push,
	output sdac_pkg::item_t                         item
);

	// accept whenever the queue has room
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// classify the command, unused codes become no-ops
	always_comb begin
		item.sample = s_tdata[sdac_pkg::SAMPLE_W-1:0];
		item.rindex = s_tdata[sdac_pkg::SAMPLE_W +: sdac_pkg::RIDX_W];
		case (s_tuser)
			sdac_pkg::CMD_SAMPLE:  item.op = sdac_pkg::OP_SAMPLE;
			sdac_pkg::CMD_PAUSE:   item.op = sdac_pkg::OP_PAUSE;
			sdac_pkg::CMD_RESUME:  item.op = sdac_pkg::OP_RESUME;
			sdac_pkg::CMD_RESTART: item.op = sdac_pkg::OP_RESTART;
			sdac_pkg::CMD_READ:    item.op = sdac_pkg::OP_READ;
			default:               item.op = sdac_pkg::OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/sdac_queue.sv @@
`default_nettype none

module sdac_queue (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire sdac_pkg::item_t                push_item,
	input  wire logic                           pop,
	output logic                                q_valid,
	output logic                                q_full,
	output sdac_pkg::item_t                     head,
	output logic [sdac_pkg::Q_CNT_W-1:0]        q_count
);

	sdac_pkg::item_t                 entry_q [sdac_pkg::Q_DEPTH];
	logic                            wr_ptr_q;
	logic                            rd_ptr_q;
	logic [sdac_pkg::Q_CNT_W-1:0]    count_q;

	assign q_valid = (count_q != '0);
	assign q_full  = (count_q == sdac_pkg::Q_CNT_W'(sdac_pkg::Q_DEPTH));
	assign head    = entry_q[rd_ptr_q];
	assign q_count = count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/sdac_back.sv @@
`default_nettype none

module sdac_back #(
	parameter int BUFFER_DEPTH = sdac_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [sdac_pkg::TB_W-1:0]          cfg_wdata,
	input  wire logic                               q_valid,
	input  wire sdac_pkg::item_t                    head,
	output logic                                    q_pop,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [sdac_pkg::M_TDATA_W-1:0]          m_tdata,
	output logic                                    m_tuser
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int SW = sdac_pkg::SAMPLE_W;
	localparam int RW = sdac_pkg::RIDX_W;
	localparam int PW = sdac_pkg::ACC_W + 16;

	typedef enum logic {
		ST_EXEC,
		ST_FINISH
	} state_t;

	state_t                         state_q;
	logic [sdac_pkg::TB_W-1:0]      tb_q;
	logic [sdac_pkg::SKIP_W-1:0]    skip_q;
	logic [sdac_pkg::AVGC_W-1:0]    avg_q;
	logic [sdac_pkg::ACC_W-1:0]     acc_q;
	logic [AW-1:0]                  wp_q;
	logic [SW-1:0]                  max_q;
	logic [SW-1:0]                  min_q;
	logic                           done_q;
	logic                           pause_q;

	logic                           store_s1;
	logic                           rd_ok_s1;
	logic [sdac_pkg::ACC_W-1:0]     acc_s1;
	logic [PW-1:0]                  prod_s1;
	logic [sdac_pkg::AVGC_W-1:0]    div_n_s1;
	logic [SW-1:0]                  rd_data_s1;

	logic                           m_valid_q;
	logic [sdac_pkg::M_TDATA_W-1:0] m_data_q;
	logic                           m_user_q;

	logic [SW-1:0]                  mem_q [BUFFER_DEPTH];

	// combinational terms
	logic [sdac_pkg::AVGC_W-1:0]    avg_n;
	logic [sdac_pkg::SKIP_W-1:0]    skip_n;
	logic                           take;
	logic                           complete;
	logic [sdac_pkg::ACC_W-1:0]     acc_sum;
	logic [15:0]                    recip;
	logic [PW-1:0]                  prod_c;
	logic [sdac_pkg::ACC_W-1:0]     quot;
	logic [SW-1:0]                  avg_val;
	logic [SW-1:0]                  max_nx;
	logic [SW-1:0]                  min_nx;
	logic                           wrap;
	logic                           done_nx;
	logic                           out_free;
	logic                           exec_go;
	logic                           finish_go;
	logic                           rd_in_range;
	logic [AW+RW-1:0]               ri_wide;
	logic [AW+RW-1:0]               wp_wide;
	logic [RW-1:0]                  pos9;

	assign out_free  = !m_valid_q || m_tready;
	assign exec_go   = (state_q == ST_EXEC) && q_valid;
	assign finish_go = (state_q == ST_FINISH) && out_free;
	assign q_pop     = exec_go;

	// execute step: skip, accumulate, reciprocal product
	assign avg_n    = sdac_pkg::avg_count(tb_q);
	assign skip_n   = sdac_pkg::skip_count(tb_q);
	assign take     = (skip_q >= skip_n);
	assign complete = (avg_q >= avg_n);
	assign acc_sum  = acc_q + sdac_pkg::ACC_W'(head.sample);
	assign recip    = (avg_n == 3'd3) ? sdac_pkg::RECIP3 : sdac_pkg::RECIP5;
	assign prod_c   = PW'(acc_sum) * PW'(recip);

	// read address, range checked against the buffer depth
	assign ri_wide     = {AW'(0), head.rindex};
	assign rd_in_range = (32'(head.rindex) < BUFFER_DEPTH);

	// finish step: quotient, saturation, extremes, wrap
	always_comb begin
		case (div_n_s1)
			3'd1:    quot = acc_s1;
			3'd2:    quot = acc_s1 >> 1;
			3'd4:    quot = acc_s1 >> 2;
			default: quot = sdac_pkg::ACC_W'(prod_s1[PW-1:sdac_pkg::RECIP_SHIFT]);
		endcase
		avg_val = (quot > sdac_pkg::ACC_W'(sdac_pkg::SAMPLE_MAX)) ? sdac_pkg::SAMPLE_MAX
		                                                          : quot[SW-1:0];
		max_nx  = (store_s1 && (avg_val > max_q)) ? avg_val : max_q;
		min_nx  = (store_s1 && (avg_val < min_q)) ? avg_val : min_q;
		wrap    = store_s1 && (wp_q == AW'(BUFFER_DEPTH - 1));
		done_nx = done_q || wrap;
	end

	assign wp_wide = {RW'(0), wp_q};
	assign pos9    = wp_wide[RW-1:0];

	// capture buffer
	always_ff @(posedge clk) begin
		if (finish_go && store_s1) begin
			mem_q[wp_q] <= avg_val;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && (head.op == sdac_pkg::OP_READ)) begin
			rd_data_s1 <= mem_q[ri_wide[AW-1:0]];
		end
	end

	// sequencer, acquisition state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_EXEC;
			tb_q      <= sdac_pkg::TB_RESET;
			skip_q    <= '0;
			avg_q     <= sdac_pkg::AVGC_W'(1);
			acc_q     <= '0;
			wp_q      <= '0;
			max_q     <= '0;
			min_q     <= sdac_pkg::SAMPLE_MAX;
			done_q    <= 1'b0;
			pause_q   <= 1'b0;
			store_s1  <= 1'b0;
			rd_ok_s1  <= 1'b0;
			acc_s1    <= '0;
			prod_s1   <= '0;
			div_n_s1  <= sdac_pkg::AVGC_W'(1);
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tb_q <= cfg_wdata;
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_EXEC: begin
					if (q_valid) begin
						store_s1 <= 1'b0;
						rd_ok_s1 <= 1'b0;
						state_q  <= ST_FINISH;
						case (head.op)
							sdac_pkg::OP_SAMPLE: begin
								if (!done_q && !pause_q) begin
									if (take) begin
										skip_q <= '0;
										if (complete) begin
											avg_q    <= sdac_pkg::AVGC_W'(1);
											acc_q    <= '0;
											acc_s1   <= acc_sum;
											prod_s1  <= prod_c;
											div_n_s1 <= avg_n;
											store_s1 <= 1'b1;
										end else begin
											avg_q <= avg_q + 1'b1;
											acc_q <= acc_sum;
										end
									end else begin
										skip_q <= skip_q + 1'b1;
									end
								end
							end
							sdac_pkg::OP_PAUSE: begin
								pause_q <= 1'b1;
							end
							sdac_pkg::OP_RESUME: begin
								pause_q <= 1'b0;
							end
							sdac_pkg::OP_RESTART: begin
								max_q   <= '0;
								min_q   <= sdac_pkg::SAMPLE_MAX;
								pause_q <= 1'b0;
								done_q  <= 1'b0;
							end
							sdac_pkg::OP_READ: begin
								rd_ok_s1 <= rd_in_range;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						max_q  <= max_nx;
						min_q  <= min_nx;
						done_q <= done_nx;
						if (store_s1) begin
							wp_q <= wrap ? '0 : wp_q + 1'b1;
						end
						m_valid_q <= 1'b1;
						m_user_q  <= store_s1;
						m_data_q  <= {6'd0,
						              rd_ok_s1 ? rd_data_s1 : SW'(0),
						              min_nx,
						              max_nx,
						              done_nx,
						              store_s1 ? pos9 : RW'(0),
						              store_s1 ? avg_val : SW'(0)};
						state_q   <= ST_EXEC;
					end
				end
				default: begin
					state_q <= ST_EXEC;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

`default_nettype wire
